// File: src/bfsi_pkg.sv
package bfsi_pkg;

    // operation codes carried in the mode field
    localparam logic MODE_PUT = 1'b0;
    localparam logic MODE_GET = 1'b1;

    // result status codes
    localparam logic [1:0] ST_PUT_DONE  = 2'd0;
    localparam logic [1:0] ST_GET_DONE  = 2'd1;
    localparam logic [1:0] ST_PUT_FULL  = 2'd2;
    localparam logic [1:0] ST_GET_EMPTY = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_SORTED_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_SIZE  = 1'd1;

    localparam logic [4:0] QUEUE_SIZE_RESET = 5'd16;

    // input word
    typedef struct packed {
        logic               mode;
        logic signed [31:0] in_value;
        logic signed [63:0] in_key;
    } t_in;

    // output word
    typedef struct packed {
        logic signed [31:0] out_value;
        logic [1:0]         status;
        logic [4:0]         fill_level;
    } t_out;

    // contents of one cell, also passed leftward on a pop
    typedef struct packed {
        logic               occ;
        logic signed [31:0] value;
        logic signed [63:0] key;
    } t_entry;

    // entry travelling rightward along the chain during an insert
    typedef struct packed {
        logic               vld;
        logic               ins;
        logic signed [31:0] value;
        logic signed [63:0] key;
    } t_carry;

    // broadcast controls for every cell
    typedef struct packed {
        logic clear;
        logic pop;
        logic sorted;
    } t_cell_ctl;

endpackage

// File: src/bfsi_cell.sv
module bfsi_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bfsi_pkg::t_cell_ctl i_ctl,
    input  bfsi_pkg::t_carry   i_carry,
    input  bfsi_pkg::t_entry   i_right,
    output bfsi_pkg::t_carry   o_carry,
    output bfsi_pkg::t_entry   o_entry
);

    logic               r_occ;
    logic signed [31:0] r_value;
    logic signed [63:0] r_key;
    bfsi_pkg::t_carry   r_carry;
    logic               take_in;

    // this cell takes the travelling word when it is free, when the slot was
    // already found upstream, or if sorted and its key is at least the new one
    assign take_in = i_carry.vld &&
                     (!r_occ || i_carry.ins ||
                      (i_ctl.sorted && (r_key >= i_carry.key)));

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_occ <= 1'b0;
        end else if (i_ctl.pop) begin
            r_occ <= i_right.occ;
        end else if (take_in) begin
            r_occ <= 1'b1;
        end
    end

    // stored value and key
    always_ff @(posedge i_clk) begin
        if (i_ctl.pop) begin
            r_value <= i_right.value;
            r_key   <= i_right.key;
        end else if (take_in) begin
            r_value <= i_carry.value;
            r_key   <= i_carry.key;
        end
    end

    // word handed to the right neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry.vld <= 1'b0;
        end else begin
            r_carry.vld <= i_carry.vld && r_occ;
        end
        if (take_in) begin
            r_carry.ins   <= 1'b1;
            r_carry.value <= r_value;
            r_carry.key   <= r_key;
        end else begin
            r_carry.ins   <= i_carry.ins;
            r_carry.value <= i_carry.value;
            r_carry.key   <= i_carry.key;
        end
    end

    assign o_carry       = r_carry;
    assign o_entry.occ   = r_occ;
    assign o_entry.value = r_value;
    assign o_entry.key   = r_key;

endmodule

// File: src/bounded_fifo_with_sorted_insert_core.sv
// channel   direction  handshake                     payload
// in        input      i_in_valid / o_in_ready       i_in_data  (bfsi_pkg::t_in)
// out       output     o_out_valid / i_out_ready     o_out_data (bfsi_pkg::t_out)
// cfg       input      i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// get and refused words: result registered at the accept edge, no insert follows
// put: result registered at the accept edge, then the new entry ripples down
//   the cell chain one cell per cycle; the next word is taken once the insert
//   state has counted down the fill level held before the put
// reset clears all cells to empty, capacity 16, fifo order
// the input stalls while an insert ripples or while a result waits unread
module bounded_fifo_with_sorted_insert_core #(
    parameter int DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  bfsi_pkg::t_in                      i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output bfsi_pkg::t_out                     o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bfsi_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bfsi_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int QW = (CW > 5) ? CW : 5;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_INSERT = 2'b10
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [CW-1:0]       r_left;
    logic                r_sorted;
    logic [4:0]          r_queue_size;
    logic                r_out_vld;
    bfsi_pkg::t_out      r_out;
    bfsi_pkg::t_carry    r_carry;
    bfsi_pkg::t_out      n_out;

    bfsi_pkg::t_carry    carries [0:DEPTH];
    bfsi_pkg::t_entry    entries [0:DEPTH];
    bfsi_pkg::t_cell_ctl ctl;

    logic                in_acc;
    logic                cfg_acc;
    logic                is_get;
    logic                empty;
    logic                full;
    logic                put_ok;
    logic                get_ok;
    logic [QW-1:0]       cap_q;
    logic [QW-1:0]       size_q;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid;
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_vld || i_out_ready);
    assign in_acc      = i_in_valid && o_in_ready;

    // effective capacity clamped to 1..DEPTH
    assign size_q = QW'(r_queue_size);
    always_comb begin
        if (size_q == '0) begin
            cap_q = QW'(1);
        end else if (size_q > QW'(DEPTH)) begin
            cap_q = QW'(DEPTH);
        end else begin
            cap_q = size_q;
        end
    end

    // decode the accepted word
    assign is_get = (i_in_data.mode == bfsi_pkg::MODE_GET);
    assign empty  = (r_count == '0);
    assign full   = (QW'(r_count) >= cap_q);
    assign put_ok = in_acc && !is_get && !full;
    assign get_ok = in_acc && is_get && !empty;

    always_comb begin
        n_count = r_count;
        if (put_ok) begin
            n_count = r_count + CW'(1);
        end else if (get_ok) begin
            n_count = r_count - CW'(1);
        end
    end

    // result word, settled at the accept edge
    always_comb begin
        n_out.out_value  = '0;
        n_out.fill_level = 5'(n_count);
        if (is_get) begin
            if (empty) begin
                n_out.status = bfsi_pkg::ST_GET_EMPTY;
            end else begin
                n_out.status    = bfsi_pkg::ST_GET_DONE;
                n_out.out_value = entries[0].value;
            end
        end else begin
            n_out.status = full ? bfsi_pkg::ST_PUT_FULL : bfsi_pkg::ST_PUT_DONE;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (in_acc) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
        if (in_acc) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // configuration registers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sorted     <= 1'b0;
            r_queue_size <= bfsi_pkg::QUEUE_SIZE_RESET;
            r_count      <= '0;
        end else if (cfg_acc) begin
            case (i_cfg_index)
                bfsi_pkg::CFG_SORTED_MODE: begin
                    r_sorted <= i_cfg_data[0];
                end
                bfsi_pkg::CFG_QUEUE_SIZE: begin
                    r_queue_size <= i_cfg_data;
                    r_count      <= '0;
                end
                default: begin
                end
            endcase
        end else begin
            r_count <= n_count;
        end
    end

    // insert sequencer: in fifo order the new entry lands at the old fill position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_carry.vld <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (put_ok) begin
                        r_state     <= S_INSERT;
                        r_carry.vld <= 1'b1;
                    end
                end
                S_INSERT: begin
                    r_carry.vld <= 1'b0;
                    if (r_left == '0) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_carry.vld <= 1'b0;
                end
            endcase
        end
        if (put_ok) begin
            r_left        <= r_count;
            r_carry.ins   <= 1'b0;
            r_carry.value <= i_in_data.in_value;
            r_carry.key   <= i_in_data.in_key;
        end else if (r_state == S_INSERT && r_left != '0) begin
            r_left <= r_left - CW'(1);
        end
    end

    // chain controls
    assign ctl.clear  = cfg_acc && (i_cfg_index == bfsi_pkg::CFG_QUEUE_SIZE);
    assign ctl.pop    = get_ok;
    assign ctl.sorted = r_sorted;

    assign carries[0]     = r_carry;
    assign entries[DEPTH] = '0;

    // row of cells, head at cell 0
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        bfsi_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_carry (carries[g]),
            .i_right (entries[g+1]),
            .o_carry (carries[g+1]),
            .o_entry (entries[g])
        );
    end

endmodule
